[rtl/core/date_to_julian_day_defines.svh]
// Assertion macros used by the date to Julian day top level
`ifndef DATE_TO_JULIAN_DAY_DEFINES_SVH
`define DATE_TO_JULIAN_DAY_DEFINES_SVH

// same-cycle implication on the block clock, off during reset
`define DJ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on the block clock, off during reset
`define DJ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/dj_pkg.sv]
// Types, constants and tables for the date to Julian day pipeline
`timescale 1ns / 1ps

package dj_pkg;

	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;
	localparam logic [6:0]  CENTURY     = 7'd100;
	localparam logic [12:0] YEAR_BIAS   = 13'd4716;
	localparam logic [10:0] DAYS_PER_4Y = 11'd1461;
	localparam logic [10:0] DAY_OFFSET  = 11'd1524;
	localparam logic [11:0] SEC_PER_HR  = 12'd3600;
	localparam logic [5:0]  SEC_PER_MIN = 6'd60;
	localparam logic [3:0]  FEB         = 4'd2;

	typedef struct packed {
		logic        bad;
		logic        early;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [26:0] q_prod;
		logic [14:0] ysum;
		logic [16:0] hsec;
		logic [11:0] msec;
	} s1_t;

	typedef struct packed {
		logic        bad;
		logic [4:0]  day;
		logic [8:0]  mterm;
		logic [8:0]  bias;
		logic [25:0] yprod;
		logic [16:0] secs;
	} s2_t;

	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} stage_en_t;

	// floor(30.6001 * (M + 1)) with January and February as months 13 and 14
	function automatic logic [8:0] month_term(input logic [3:0] m);
		logic [8:0] t;
		unique case (m)
			4'd1:    t = 9'd428;
			4'd2:    t = 9'd459;
			4'd3:    t = 9'd122;
			4'd4:    t = 9'd153;
			4'd5:    t = 9'd183;
			4'd6:    t = 9'd214;
			4'd7:    t = 9'd244;
			4'd8:    t = 9'd275;
			4'd9:    t = 9'd306;
			4'd10:   t = 9'd336;
			4'd11:   t = 9'd367;
			4'd12:   t = 9'd397;
			default: t = 9'd0;
		endcase
		return t;
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] m);
		logic [4:0] d;
		unique case (m)
			4'd2:                       d = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
			default:                    d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

[rtl/core/dj_stage1.sv]
// Stage 1: range checks, year reciprocal product, time partial sums
`timescale 1ns / 1ps

module dj_stage1 import dj_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [4:0]  day_of_month,
	input  logic [3:0]  month_number,
	input  logic [13:0] year_number,
	input  logic [4:0]  hour_of_day,
	input  logic [5:0]  minute_of_hour,
	input  logic [5:0]  second_of_minute,
	output s1_t         data_s1
);

	s1_t nxt;

	always_comb begin
		nxt.bad    = (month_number < 4'd1) || (month_number > 4'd12) ||
		             (day_of_month == 5'd0) || (hour_of_day > 5'd23) ||
		             (minute_of_hour > 6'd59) || (second_of_minute > 6'd59);
		nxt.early  = (month_number <= FEB);
		nxt.day    = day_of_month;
		nxt.month  = month_number;
		nxt.year   = year_number;
		nxt.q_prod = 27'(year_number) * 27'(RECIP_100);
		nxt.ysum   = 15'(year_number) + 15'(YEAR_BIAS) - 15'(nxt.early);
		nxt.hsec   = 17'(hour_of_day) * 17'(SEC_PER_HR);
		nxt.msec   = 12'(minute_of_hour) * 12'(SEC_PER_MIN) + 12'(second_of_minute);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

[rtl/core/dj_stage2.sv]
// Stage 2: century split, leap rule, day limit, century bias, year product
`timescale 1ns / 1ps

module dj_stage2 import dj_pkg::*; (
	input  logic clk,
	input  logic en,
	input  s1_t  data_s1,
	output s2_t  data_s2
);

	logic [7:0]        q;
	logic [13:0]       rem;
	logic              r_zero;
	logic              leap;
	logic [4:0]        lim;
	logic signed [8:0] cent;
	s2_t               nxt;

	always_comb begin
		q      = data_s1.q_prod[RECIP_SHIFT +: 8];
		rem    = data_s1.year - 14'(q) * 14'(CENTURY);
		r_zero = (rem == 14'd0);
		leap   = (data_s1.year[1:0] == 2'b00 && !r_zero) || (r_zero && q[1:0] == 2'b00);
		lim    = month_days(data_s1.month) + 5'((data_s1.month == FEB) && leap);
		cent   = $signed({1'b0, q}) - $signed({8'd0, data_s1.early && r_zero});
		nxt.bad   = data_s1.bad || (data_s1.day > lim);
		nxt.day   = data_s1.day;
		nxt.mterm = month_term(data_s1.month);
		nxt.bias  = 9'sd2 - cent + (cent >>> 2);
		nxt.yprod = 26'(data_s1.ysum) * 26'(DAYS_PER_4Y);
		nxt.secs  = data_s1.hsec + 17'(data_s1.msec);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= nxt;
		end
	end

endmodule

[rtl/core/dj_stage3.sv]
// Stage 3: day number sum and result register
`timescale 1ns / 1ps

module dj_stage3 import dj_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  s2_t         data_s2,
	output logic        invalid_s3,
	output logic [22:0] day_s3,
	output logic [16:0] secs_s3
);

	logic signed [24:0] n_full;

	always_comb begin
		n_full = $signed({2'b00, data_s2.yprod[24:2]})
		       + $signed({16'd0, data_s2.mterm})
		       + $signed({20'd0, data_s2.day})
		       + $signed({{16{data_s2.bias[8]}}, data_s2.bias})
		       - $signed({14'd0, DAY_OFFSET});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			invalid_s3 <= data_s2.bad;
			day_s3     <= data_s2.bad ? 23'd0 : n_full[22:0];
			secs_s3    <= data_s2.bad ? 17'd0 : data_s2.secs;
		end
	end

endmodule

[rtl/core/date_to_julian_day.sv]
// Pipeline: three register stages; a request passes stages 1, 2 and 3 in order,
// and the stage 3 valid bit drives out_valid. Throughput: one request per cycle
// unless out_ready stalls; stages advance independently, so bubbles fill while
// the result waits. The year multipliers in stages 1 and 2 set depth.
// Reset: arst_n clears all stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps

`include "date_to_julian_day_defines.svh"

module date_to_julian_day import dj_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  day_of_month,
	input  logic [3:0]  month_number,
	input  logic [13:0] year_number,
	input  logic [4:0]  hour_of_day,
	input  logic [5:0]  minute_of_hour,
	input  logic [5:0]  second_of_minute,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        date_invalid,
	output logic [22:0] day_number,
	output logic [16:0] seconds_into_day
);

	logic      v_s1, v_s2, v_s3;
	stage_en_t en;
	s1_t       data_s1;
	s2_t       data_s2;

	always_comb begin
		en.en3 = !v_s3 || out_ready;
		en.en2 = !v_s2 || en.en3;
		en.en1 = !v_s1 || en.en2;
	end

	assign in_ready  = en.en1;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en.en1) v_s1 <= in_valid;
			if (en.en2) v_s2 <= v_s1;
			if (en.en3) v_s3 <= v_s2;
		end
	end

	dj_stage1 u_stage1 (
		.clk              (clk),
		.en               (en.en1),
		.day_of_month     (day_of_month),
		.month_number     (month_number),
		.year_number      (year_number),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute),
		.data_s1          (data_s1)
	);

	dj_stage2 u_stage2 (
		.clk     (clk),
		.en      (en.en2),
		.data_s1 (data_s1),
		.data_s2 (data_s2)
	);

	dj_stage3 u_stage3 (
		.clk        (clk),
		.en         (en.en3),
		.data_s2    (data_s2),
		.invalid_s3 (date_invalid),
		.day_s3     (day_number),
		.secs_s3    (seconds_into_day)
	);

	`DJ_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, v_s1, "accepted request lost")
	`DJ_ASSERT_NEXT(a_s2_holds, v_s2 && !en.en3, v_s2, "stalled stage 2 dropped")
	`DJ_ASSERT_NOW(a_invalid_zero, out_valid && date_invalid,
		day_number == 23'd0 && seconds_into_day == 17'd0, "invalid result not zeroed")
	`DJ_ASSERT_NOW(a_secs_range, out_valid && !date_invalid,
		seconds_into_day < 17'd86400, "second of day out of range")

endmodule

[tb/sv/date_to_julian_day_test.sv]
// Self-checking testbench for the Gregorian date to Julian day number pipeline
`timescale 1ns / 1ps

module date_to_julian_day_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic        bad;
		logic [22:0] jdn;
		logic [16:0] secs;
	} julian_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [4:0]  day_of_month = '0;
	logic [3:0]  month_number = '0;
	logic [13:0] year_number = '0;
	logic [4:0]  hour_of_day = '0;
	logic [5:0]  minute_of_hour = '0;
	logic [5:0]  second_of_minute = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        date_invalid;
	logic [22:0] day_number;
	logic [16:0] seconds_into_day;

	julian_t julian_pending[$];
	int      mismatch_count = 0;
	int      cycle_count = 0;
	int      sender_idle_pct = 0;
	int      stall_pct = 0;
	logic    hold_active = 1'b0;

	date_to_julian_day dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.day_of_month     (day_of_month),
		.month_number     (month_number),
		.year_number      (year_number),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.date_invalid     (date_invalid),
		.day_number       (day_number),
		.seconds_into_day (seconds_into_day)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int floor_quot(input int a, input int b);
		int q;
		q = a / b;
		if ((a % b != 0) && (a < 0))
			q = q - 1;
		return q;
	endfunction

	function automatic logic [4:0] month_length(input logic [3:0] m, input logic [13:0] y);
		logic leap;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		case (m)
			4'd2:                    return leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
			default:                 return 5'd31;
		endcase
	endfunction

	function automatic julian_t predict_julian(input logic [4:0] d, input logic [3:0] m,
			input logic [13:0] y, input logic [4:0] h, input logic [5:0] mi,
			input logic [5:0] s);
		julian_t r;
		int yy, mm, dd, cent, corr, n, sec;
		r = '0;
		if (m < 4'd1 || m > 4'd12 || d < 5'd1 || h > 5'd23 || mi > 6'd59 || s > 6'd59 ||
				d > month_length(m, y)) begin
			r.bad = 1'b1;
			return r;
		end
		yy = int'(y);
		mm = int'(m);
		dd = int'(d);
		if (mm <= 2) begin
			yy = yy - 1;
			mm = mm + 12;
		end
		cent = floor_quot(yy, 100);
		corr = 2 - cent + floor_quot(cent, 4);
		n = (1461 * (yy + 4716)) / 4 + (306001 * (mm + 1)) / 10000 + dd + corr - 1524;
		sec = int'(h) * 3600 + int'(mi) * 60 + int'(s);
		r.jdn = n[22:0];
		r.secs = sec[16:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int want, input int got);
		$display("mismatch on %s: expected %0d, got %0d at cycle %0d", what, want, got,
			cycle_count);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				julian_pending.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_active)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		julian_t want;
		if (arst_n && out_valid && out_ready) begin
			if (julian_pending.size() == 0) begin
				report_mismatch("unexpected result", 0, 1);
			end else begin
				want = julian_pending.pop_front();
				if (date_invalid !== want.bad)
					report_mismatch("date_invalid", want.bad, date_invalid);
				if (day_number !== want.jdn)
					report_mismatch("day_number", want.jdn, day_number);
				if (seconds_into_day !== want.secs)
					report_mismatch("seconds_into_day", want.secs, seconds_into_day);
			end
		end
	end

	task automatic send_date(input logic [4:0] d, input logic [3:0] m, input logic [13:0] y,
			input logic [4:0] h, input logic [5:0] mi, input logic [5:0] s);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < sender_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid         <= 1'b1;
		day_of_month     <= d;
		month_number     <= m;
		year_number      <= y;
		hour_of_day      <= h;
		minute_of_hour   <= mi;
		second_of_minute <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		julian_pending.push_back(predict_julian(d, m, y, h, mi, s));
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (julian_pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_date();
		logic [4:0]  d, month_end;
		logic [3:0]  m;
		logic [13:0] y;
		logic [4:0]  h;
		logic [5:0]  mi, s;
		int          kind, pick;
		kind = $urandom_range(0, 99);
		pick = $urandom_range(0, 99);
		if (pick < 45)
			y = 14'($urandom());
		else if (pick < 70)
			y = 14'($urandom_range(0, 9999));
		else if (pick < 85)
			y = 14'($urandom_range(0, 163) * 100);
		else if (pick < 92)
			y = 14'($urandom_range(0, 8));
		else
			y = 14'($urandom_range(16376, 16383));
		m = 4'($urandom_range(1, 12));
		month_end = month_length(m, y);
		d = ($urandom_range(0, 4) == 0) ? month_end : 5'($urandom_range(1, month_end));
		h = 5'($urandom_range(0, 23));
		mi = 6'($urandom_range(0, 59));
		s = 6'($urandom_range(0, 59));
		if (kind >= 70 && kind < 85) begin
			case ($urandom_range(0, 5))
				0: d = (month_end == 5'd31) ? 5'd0 : month_end + 5'd1;
				1: d = 5'd0;
				2: h = 5'($urandom_range(24, 31));
				3: mi = 6'($urandom_range(60, 63));
				4: s = 6'($urandom_range(60, 63));
				default: m = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
			endcase
		end else if (kind >= 85) begin
			d = 5'($urandom());
			m = 4'($urandom());
			y = 14'($urandom());
			h = 5'($urandom());
			mi = 6'($urandom());
			s = 6'($urandom());
		end
		send_date(d, m, y, h, mi, s);
	endtask

	task automatic test_directed();
		sender_idle_pct = 0;
		stall_pct = 0;
		send_date(5'd1, 4'd1, 14'd0, 5'd0, 6'd0, 6'd0);
		send_date(5'd29, 4'd2, 14'd0, 5'd23, 6'd59, 6'd59);
		send_date(5'd1, 4'd3, 14'd0, 5'd12, 6'd0, 6'd0);
		send_date(5'd1, 4'd1, 14'd2000, 5'd12, 6'd0, 6'd0);
		send_date(5'd29, 4'd2, 14'd2000, 5'd0, 6'd0, 6'd1);
		send_date(5'd29, 4'd2, 14'd1900, 5'd0, 6'd0, 6'd0);
		send_date(5'd29, 4'd2, 14'd2024, 5'd6, 6'd30, 6'd0);
		send_date(5'd29, 4'd2, 14'd2023, 5'd6, 6'd30, 6'd0);
		send_date(5'd15, 4'd10, 14'd1582, 5'd0, 6'd0, 6'd0);
		send_date(5'd31, 4'd12, 14'd9999, 5'd23, 6'd59, 6'd59);
		send_date(5'd31, 4'd12, 14'd16383, 5'd23, 6'd59, 6'd59);
		send_date(5'd1, 4'd1, 14'd16383, 5'd0, 6'd0, 6'd0);
		send_date(5'd31, 4'd1, 14'd1970, 5'd1, 6'd2, 6'd3);
		send_date(5'd0, 4'd5, 14'd1999, 5'd1, 6'd2, 6'd3);
		send_date(5'd31, 4'd4, 14'd1999, 5'd1, 6'd2, 6'd3);
		send_date(5'd30, 4'd4, 14'd1999, 5'd1, 6'd2, 6'd3);
		send_date(5'd10, 4'd0, 14'd1999, 5'd1, 6'd2, 6'd3);
		send_date(5'd10, 4'd13, 14'd1999, 5'd1, 6'd2, 6'd3);
		send_date(5'd31, 4'd15, 14'd1999, 5'd1, 6'd2, 6'd3);
		send_date(5'd10, 4'd6, 14'd2010, 5'd24, 6'd0, 6'd0);
		send_date(5'd10, 4'd6, 14'd2010, 5'd0, 6'd60, 6'd0);
		send_date(5'd10, 4'd6, 14'd2010, 5'd0, 6'd0, 6'd60);
		send_date(5'd31, 4'd15, 14'd16383, 5'd31, 6'd63, 6'd63);
		send_date(5'd1, 4'd3, 14'd1600, 5'd23, 6'd0, 6'd0);
		wait_drain();
	endtask

	task automatic test_random_phase(input int count, input int idle_pct, input int hold_pct);
		sender_idle_pct = idle_pct;
		stall_pct = hold_pct;
		repeat (count) send_random_date();
		wait_drain();
	endtask

	task automatic test_backpressure();
		sender_idle_pct = 0;
		stall_pct = 0;
		fork
			begin
				hold_active <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active <= 1'b0;
			end
		join_none
		repeat (40) send_random_date();
		wait_drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(380, 0, 0);
		test_random_phase(380, 72, 0);
		test_random_phase(380, 0, 72);
		test_random_phase(380, 29, 29);
		test_backpressure();
		wait_drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && julian_pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/dj_pkg.sv
rtl/core/dj_stage1.sv
rtl/core/dj_stage2.sv
rtl/core/dj_stage3.sv
rtl/core/date_to_julian_day.sv
tb/sv/date_to_julian_day_test.sv
